// ===== rtl/cgt_pkg.sv =====
// ============================================================================
// cgt_pkg
// Shared types and constants of the chordality test block: word widths,
// engine states and the control and status groups of the search engine.
// ============================================================================
package cgt_pkg;

    // Fixed field widths of the stream words.
    localparam int ROW_W     = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // Sequencer states of the search and clique check engine.
    typedef enum logic [3:0] {
        ES_IDLE,
        ES_SCAN,
        ES_PICK_RD,
        ES_PICK_UPD,
        ES_CV_RD,
        ES_CV,
        ES_CA_RD,
        ES_CA,
        ES_DONE
    } t_eng_state;

    // Control from the stream side to the engine.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] n;
        logic             ack;
    } t_eng_ctl;

    // Status from the engine back to the stream side.
    typedef struct packed {
        logic done;
        logic result;
    } t_eng_stat;

endpackage

// ===== rtl/cgt_adj_ram.sv =====
// ============================================================================
// cgt_adj_ram
// Adjacency row store: one write port, one read port, registered read data.
// ============================================================================
module cgt_adj_ram #(
    parameter int NUM_V = 16
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(NUM_V)-1:0]    i_waddr,
    input  logic [cgt_pkg::ROW_W-1:0]   i_wdata,
    input  logic [$clog2(NUM_V)-1:0]    i_raddr,
    output logic [cgt_pkg::ROW_W-1:0]   o_rdata
);

    logic [cgt_pkg::ROW_W-1:0] r_mem [NUM_V];
    logic [cgt_pkg::ROW_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cgt_engine.sv =====
// ============================================================================
// cgt_engine
// Maximum cardinality search over the stored rows, then a check that the
// neighbors of each vertex with a higher elimination number are pairwise adjacent.
// ============================================================================
module cgt_engine #(
    parameter int NUM_V = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cgt_pkg::t_eng_ctl           i_ctl,
    output cgt_pkg::t_eng_stat          o_stat,
    output logic [$clog2(NUM_V)-1:0]    o_raddr,
    input  logic [cgt_pkg::ROW_W-1:0]   i_rdata
);

    localparam int IW = $clog2(NUM_V);
    localparam int CW = $clog2(NUM_V + 1);

    cgt_pkg::t_eng_state r_state, n_state;

    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_step;
    logic [IW-1:0]    r_i;
    logic [IW-1:0]    r_v;
    logic [IW-1:0]    r_a;
    logic [IW-1:0]    r_best_idx;
    logic [IW-1:0]    r_best_w;
    logic             r_found;
    logic             r_result;
    logic [NUM_V-1:0] r_picked;
    logic [NUM_V-1:0] r_higher;
    logic [IW-1:0]    r_w    [NUM_V];
    logic [CW-1:0]    r_elim [NUM_V];

    logic [NUM_V-1:0] row;
    logic [NUM_V-1:0] hb;
    logic [NUM_V-1:0] above;
    logic             take;
    logic             i_last;
    logic             v_last;
    logic             a_last;
    logic             step_last;
    logic             fail;

    assign row = i_rdata[NUM_V-1:0];

    // Position flags of the loop counters.
    assign i_last    = ((CW + 1)'(r_i) + 1'b1 == (CW + 1)'(r_n));
    assign v_last    = ((CW + 1)'(r_v) + 1'b1 == (CW + 1)'(r_n));
    assign a_last    = ((CW + 1)'(r_a) + 1'b1 == (CW + 1)'(r_n));
    assign step_last = ((CW + 1)'(r_step) + 1'b1 == (CW + 1)'(r_n));

    // Scan candidate: unselected and strictly heavier than the best so far.
    assign take = !r_picked[r_i] && (!r_found || (r_w[r_i] > r_best_w));

    // Neighbors of vertex v with a higher elimination number and the pair test for vertex a.
    always_comb begin
        for (int u = 0; u < NUM_V; u++) begin
            hb[u]    = (CW'(u) < r_n) && (IW'(u) != r_v) && row[u] &&
                       (r_elim[u] > r_elim[r_v]);
            above[u] = (IW'(u) > r_a);
        end
        fail = |(r_higher & above & ~row);
    end

    // Memory read address for the next data cycle.
    always_comb begin
        case (r_state)
            cgt_pkg::ES_PICK_RD: o_raddr = r_best_idx;
            cgt_pkg::ES_CV_RD:   o_raddr = r_v;
            default:             o_raddr = r_a;
        endcase
    end

    assign o_stat.done   = (r_state == cgt_pkg::ES_DONE);
    assign o_stat.result = r_result;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cgt_pkg::ES_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cgt_pkg::ES_IDLE: begin
                if (i_ctl.start) n_state = cgt_pkg::ES_SCAN;
            end
            cgt_pkg::ES_SCAN: begin
                if (i_last) n_state = cgt_pkg::ES_PICK_RD;
            end
            cgt_pkg::ES_PICK_RD: begin
                n_state = cgt_pkg::ES_PICK_UPD;
            end
            cgt_pkg::ES_PICK_UPD: begin
                n_state = step_last ? cgt_pkg::ES_CV_RD : cgt_pkg::ES_SCAN;
            end
            cgt_pkg::ES_CV_RD: begin
                n_state = cgt_pkg::ES_CV;
            end
            cgt_pkg::ES_CV: begin
                n_state = cgt_pkg::ES_CA_RD;
            end
            cgt_pkg::ES_CA_RD, cgt_pkg::ES_CA: begin
                if (r_state == cgt_pkg::ES_CA && fail) begin
                    n_state = cgt_pkg::ES_DONE;
                end else if (r_state == cgt_pkg::ES_CA_RD && r_higher[r_a]) begin
                    n_state = cgt_pkg::ES_CA;
                end else if (a_last) begin
                    n_state = v_last ? cgt_pkg::ES_DONE : cgt_pkg::ES_CV_RD;
                end else begin
                    n_state = cgt_pkg::ES_CA_RD;
                end
            end
            cgt_pkg::ES_DONE: begin
                if (i_ctl.ack) n_state = cgt_pkg::ES_IDLE;
            end
            default: n_state = cgt_pkg::ES_IDLE;
        endcase
    end

    // Datapath registers of the search and the check.
    always_ff @(posedge i_clk) begin
        case (r_state)
            cgt_pkg::ES_IDLE: begin
                if (i_ctl.start) begin
                    r_n      <= i_ctl.n[CW-1:0];
                    r_step   <= '0;
                    r_i      <= '0;
                    r_found  <= 1'b0;
                    r_picked <= '0;
                    for (int u = 0; u < NUM_V; u++) begin
                        r_w[u]    <= '0;
                        r_elim[u] <= '0;
                    end
                end
            end
            cgt_pkg::ES_SCAN: begin
                if (take) begin
                    r_best_idx <= r_i;
                    r_best_w   <= r_w[r_i];
                    r_found    <= 1'b1;
                end
                r_i <= r_i + 1'b1;
            end
            cgt_pkg::ES_PICK_RD: begin
                r_picked[r_best_idx] <= 1'b1;
                r_elim[r_best_idx]   <= r_n - r_step;
            end
            cgt_pkg::ES_PICK_UPD: begin
                // Raise the weight of every unselected neighbor of the pick.
                for (int u = 0; u < NUM_V; u++) begin
                    if (!r_picked[u] && row[u]) r_w[u] <= r_w[u] + 1'b1;
                end
                r_step  <= r_step + 1'b1;
                r_i     <= '0;
                r_found <= 1'b0;
                r_v     <= '0;
            end
            cgt_pkg::ES_CV: begin
                r_higher <= hb;
                r_a      <= '0;
            end
            cgt_pkg::ES_CA_RD, cgt_pkg::ES_CA: begin
                if (r_state == cgt_pkg::ES_CA && fail) begin
                    r_result <= 1'b0;
                end else if (r_state == cgt_pkg::ES_CA_RD && r_higher[r_a]) begin
                    r_a <= r_a;
                end else if (a_last) begin
                    if (v_last) r_result <= 1'b1;
                    r_v <= r_v + 1'b1;
                end else begin
                    r_a <= r_a + 1'b1;
                end
            end
            default: begin
                r_n <= r_n;
            end
        endcase
    end

endmodule

// ===== rtl/chordal_graph_test_mcs.sv =====
// ============================================================================
// chordal_graph_test_mcs
// Chordality test of a small undirected graph by maximum cardinality search.
// ============================================================================
//  channel   direction  word                       notes
//  s_axis    in         tdata: row_index, row_bits tlast marks the final row
//  m_axis    out        tdata: is_chordal          one word per graph
//
// Rows are taken one per cycle into the adjacency memory while the engine
// is idle. After the final row the engine runs a search phase and then a
// check phase. The search scans the weights one vertex per cycle, and both
// phases read rows through the single memory read port.
// While the engine runs, s_axis tready is low. A finished word waits in the
// output register, and rows of the next graph are taken meanwhile.
// Reset is synchronous and active low and clears all control state.
// ============================================================================
module chordal_graph_test_mcs #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [3:0] row_index, [19:4] row_bits, [23:20] zero
    input  logic [cgt_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] is_chordal, [7:1] zero
    output logic [cgt_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int NV = (MAX_VERTICES < cgt_pkg::ROW_W) ? MAX_VERTICES : cgt_pkg::ROW_W;
    localparam int IW = $clog2(NV);

    logic                          r_busy;
    logic                          r_out_valid;
    logic                          r_out_data;
    logic                          accept;
    logic [cgt_pkg::IDX_W-1:0]     row_index;
    logic [cgt_pkg::ROW_W-1:0]     row_bits;
    logic [cgt_pkg::CNT_W-1:0]     count_raw;
    logic [IW-1:0]                 raddr;
    logic [cgt_pkg::ROW_W-1:0]     rdata;
    cgt_pkg::t_eng_ctl             ctl;
    cgt_pkg::t_eng_stat            stat;

    assign row_index = i_s_axis_tdata[cgt_pkg::IDX_W-1:0];
    assign row_bits  = i_s_axis_tdata[cgt_pkg::IDX_W +: cgt_pkg::ROW_W];
    assign o_s_axis_tready = !r_busy;
    assign accept = i_s_axis_tvalid && !r_busy;

    // Vertex count from the final row, saturated at the store depth.
    assign count_raw = cgt_pkg::CNT_W'(row_index) + 1'b1;
    assign ctl.start = accept && i_s_axis_tlast;
    assign ctl.n     = (count_raw > cgt_pkg::CNT_W'(NV)) ? cgt_pkg::CNT_W'(NV) : count_raw;
    assign ctl.ack   = !r_out_valid || i_m_axis_tready;

    cgt_adj_ram #(
        .NUM_V (NV)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && (cgt_pkg::CNT_W'(row_index) < cgt_pkg::CNT_W'(NV))),
        .i_waddr (row_index[IW-1:0]),
        .i_wdata (row_bits),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cgt_engine #(
        .NUM_V (NV)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    // Busy flag and output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctl.start) begin
                r_busy <= 1'b1;
            end
            if (stat.done && ctl.ack) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done && ctl.ack) begin
            r_out_data <= stat.result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(cgt_pkg::M_TDATA_W - 1){1'b0}}, r_out_data};

endmodule

// ===== rtl/cgt_checker.sv =====
// ============================================================================
// cgt_checker
// Port-level checks of the chordality test block, bound to the top level.
// ============================================================================
module cgt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [cgt_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    input logic                            i_s_axis_tlast,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [cgt_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    // The padding bits of the output word stay zero.
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[cgt_pkg::M_TDATA_W-1:1] == '0))
        else $error("output padding bits set");

    // The final row of a graph starts the engine, which blocks new rows.
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("row accepted right after a final row");

    // A new result word appears exactly when the engine hands back the input.
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $rose(o_s_axis_tready))
        else $error("result word without release of the input side");

endmodule

bind chordal_graph_test_mcs cgt_checker u_cgt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
